@@ rtl/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// plid_pkg: shared types and constants for the positional list
// Holds the list depth, request and response beat types, status and opcode
// values, and the control word that is broadcast along the row of cells.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Common width for comparing a position against the count.
  localparam int unsigned CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic               func;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         item_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   target;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/plid_cell.sv @@
// ----------------------------------------------------------------------------
// plid_cell: one slot of the list
// Holds one entry and, on a broadcast command, keeps it, loads the new value,
// or takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module plid_cell import plid_pkg::*; (
  input  logic                      clk_i,
  input  logic [IDX_W-1:0]          cell_idx_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [31:0]        left_i,
  input  logic signed [31:0]        right_i,
  output logic signed [31:0]        data_o
);

  logic signed [31:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (cell_idx_i > ctrl_i.target) begin
          data_d = left_i;
        end else if (cell_idx_i == ctrl_i.target) begin
          data_d = ctrl_i.value;
        end
      end
      OP_DELETE: begin
        if (cell_idx_i >= ctrl_i.target) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/plid_row.sv @@
// ----------------------------------------------------------------------------
// plid_row: chain of list cells
// Links the cells to their neighbors so that an insert shifts the tail back
// and a delete shifts it forward in the same cycle. Also selects the entry
// at the target slot for a delete.
// ----------------------------------------------------------------------------
module plid_row import plid_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  output logic signed [31:0] sel_data_o
);

  logic signed [31:0] data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left, right;

    // The first cell never takes from the left, and the last takes from the right
    // only on a delete, when it falls outside the count, so those inputs carry filler values.
    if (g == 0) begin : g_first
      assign left = ctrl_i.value;
    end else begin : g_mid_l
      assign left = data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[g+1];
    end

    plid_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl_i),
      .left_i     (left),
      .right_i    (right),
      .data_o     (data[g])
    );
  end

  assign sel_data_o = data[ctrl_i.target];

endmodule

@@ rtl/positional_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with insert/delete by position
// Keeps up to DEPTH signed items in a row of shifting cells; a request
// inserts or removes one item at a 1-based position and returns one result.
//
//   channel   ports                   handshake
//   request   start, busy, req_i      beat taken when start && !busy
//   result    done_o, rsp_o           one-cycle strobe, cannot be held off
//
// All cells shift in parallel at the edge that accepts a request, and the
// result is shown in the following cycle. busy stays low, so a new request
// may be given every cycle. Reset empties the list; the entry contents are
// not cleared since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete import plid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  logic               accept;
  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic [1:0]         status;
  cell_ctrl_t         ctrl;
  logic signed [31:0] sel_data;
  logic [CNT_W-1:0]   count_d, count_q;
  logic               done_d, done_q;
  rsp_t               rsp_d, rsp_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    if (req_i.func == FUNC_DELETE) begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
        status = ST_RANGE;
      end else begin
        status = ST_OK;
      end
    end else begin
      // The position check takes priority over the full check.
      if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
        status = ST_RANGE;
      end else if (cnt_ext == CMP_W'(DEPTH)) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end
  end

  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.target = IDX_W'(pos_ext - CMP_W'(1));
    ctrl.value  = req_i.item_value;
    count_d     = count_q;
    if (accept && status == ST_OK) begin
      if (req_i.func == FUNC_DELETE) begin
        ctrl.op = OP_DELETE;
        count_d = count_q - CNT_W'(1);
      end else begin
        ctrl.op = OP_INSERT;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  plid_row u_row (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .sel_data_o (sel_data)
  );

  always_comb begin
    done_d               = accept;
    rsp_d.status         = status;
    rsp_d.item_count     = 5'(count_d);
    rsp_d.removed_value  = (req_i.func == FUNC_DELETE && status == ST_OK) ? sel_data : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/plid_checker.sv @@
// ----------------------------------------------------------------------------
// plid_checker: port-level checks for the positional list
// Watches request and result beats on the top level and flags results that
// break the timing or the status rules.
// ----------------------------------------------------------------------------
module plid_checker import plid_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // Every accepted beat gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a request");

  a_failed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.removed_value == '0))
    else $error("failed request returned a value");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.item_count == '0))
    else $error("empty status with nonzero count");

  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.func == FUNC_INSERT) |=> (rsp_o.removed_value == '0))
    else $error("insert returned a removed value");

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_list_insert_delete
// Sends insert and delete requests in random bursts and checks every response
// against a behavioral copy of the list that the bench updates on each
// accepted request. A short directed sequence covers the corner cases first:
// the empty list, bad positions, a full list and the value extremes.
// ----------------------------------------------------------------------------
module testbench;
  import plid_pkg::*;

  localparam int unsigned N_RANDOM = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_d = '0;
  logic done_o;
  rsp_t rsp_o;

  positional_list_insert_delete uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_d),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_issued = 0;
  int   n_accepted = 0;
  int   fail_count = 0;
  int   shown = 0;

  // Bench copy of the list contents and its length.
  logic signed [31:0] list_mem [DEPTH];
  int                 list_len = 0;

  // Count as the stimulus generator expects it, to build well-formed requests.
  int plan_len = 0;

  // Applies one request to the bench copy of the list and returns the response.
  task automatic list_update(input req_t r, output rsp_t rsp);
    int pos;
    pos = int'(r.position);
    rsp = '0;
    if (r.func == FUNC_INSERT) begin
      if (pos < 1 || pos > list_len + 1) begin
        rsp.status = ST_RANGE;
      end else if (list_len >= DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        for (int i = list_len; i > pos - 1; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos-1] = r.item_value;
        list_len++;
        rsp.status = ST_OK;
      end
    end else begin
      if (list_len == 0) begin
        rsp.status = ST_EMPTY;
      end else if (pos < 1 || pos > list_len) begin
        rsp.status = ST_RANGE;
      end else begin
        rsp.removed_value = list_mem[pos-1];
        for (int i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
        rsp.status = ST_OK;
      end
    end
    rsp.item_count = list_len[4:0];
  endtask

  task automatic queue_req(input logic f, input int pos, input logic [31:0] v);
    req_t r;
    r.func = f;
    r.position = pos[4:0];
    r.item_value = v;
    pending_reqs.push_back(r);
    n_issued++;
    if (f == FUNC_INSERT) begin
      if (pos >= 1 && pos <= plan_len + 1 && plan_len < DEPTH) plan_len++;
    end else if (plan_len > 0 && pos >= 1 && pos <= plan_len) begin
      plan_len--;
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Driver: requests go out in bursts of random length with random gaps.
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic next_start;
    req_t next_req;
    if (!rst_ni) begin
      start <= 1'b0;
      req_d <= '0;
    end else if (!start || !busy) begin
      next_start = 1'b0;
      next_req = req_d;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        next_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= next_start;
      req_d <= next_req;
    end
  end

  // Monitor: the response for a beat shows up in the cycle after it is taken.
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (shown < 10) $display("unexpected response: removed=%0d status=%0d count=%0d",
                                   rsp_o.removed_value, rsp_o.status, rsp_o.item_count);
          shown++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o.removed_value !== want.removed_value || rsp_o.status !== want.status ||
              rsp_o.item_count !== want.item_count) begin
            fail_count++;
            if (shown < 10)
              $display("mismatch: expected removed=%0d status=%0d count=%0d, got %0d %0d %0d",
                       want.removed_value, want.status, want.item_count,
                       rsp_o.removed_value, rsp_o.status, rsp_o.item_count);
            shown++;
          end
        end
      end
      if (start && !busy) begin
        list_update(req_d, want);
        expected_rsps.push_back(want);
        n_accepted++;
      end
    end
  end

  initial begin
    int  k;
    int  pos;
    int  choice;
    logic fill_mode;
    logic do_insert;

    // Delete from an empty list, whatever the position.
    queue_req(FUNC_DELETE, 0, 32'h0);
    queue_req(FUNC_DELETE, 17, 32'hffff_ffff);
    queue_req(FUNC_DELETE, 5, 32'h1234_5678);
    // Insert at a bad position on an empty list.
    queue_req(FUNC_INSERT, 0, 32'h5555_5555);
    queue_req(FUNC_INSERT, 2, 32'haaaa_aaaa);
    // Valid inserts with the value extremes, at the front, the end and the middle.
    queue_req(FUNC_INSERT, 1, 32'h7fff_ffff);
    queue_req(FUNC_INSERT, 1, 32'h8000_0000);
    queue_req(FUNC_INSERT, 3, 32'hffff_ffff);
    queue_req(FUNC_INSERT, 2, 32'h0000_0000);
    // Delete at a bad position on a non-empty list.
    queue_req(FUNC_DELETE, 0, 32'h0);
    queue_req(FUNC_DELETE, 5, 32'h0);
    // Fill the list, then hit it with an insert at the one-past-end position
    // (full) and at position zero (the range check wins).
    for (k = 0; plan_len < DEPTH; k++) begin
      pos = (k % 3 == 0) ? 1 : (k % 3 == 1) ? plan_len + 1 : plan_len / 2 + 1;
      queue_req(FUNC_INSERT, pos, $urandom);
    end
    queue_req(FUNC_INSERT, 17, 32'h0bad_0bad);
    queue_req(FUNC_INSERT, 0, 32'h0bad_0bad);
    queue_req(FUNC_DELETE, 16, 32'h0);
    queue_req(FUNC_DELETE, 1, 32'h0);

    // Random part: mostly valid requests, with a fill or drain bias that
    // flips now and then so the list swings between empty and full.
    fill_mode = 1'b1;
    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 39) == 0) fill_mode = ~fill_mode;
      choice = $urandom_range(0, 9);
      if (choice < 2) begin
        queue_req(logic'($urandom_range(0, 1)), $urandom_range(0, 17), pick_value());
      end else begin
        do_insert = fill_mode ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
        if (plan_len == 0) do_insert = 1'b1;
        if (do_insert) queue_req(FUNC_INSERT, $urandom_range(1, plan_len + 1), pick_value());
        else queue_req(FUNC_DELETE, $urandom_range(1, plan_len), $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_issued) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
